// File: sv/srcf_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// srcf_pkg: shared definitions for the slice ramp crossfade
// Register indexes, fixed field widths and the operand bundle handed to the
// serial blend unit.
// ============================================================================
package srcf_pkg;

    // Fixed widths of the configuration registers.
    localparam int COUNT_BITS     = 13;
    localparam int RAMP_BITS      = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 3;

    // Defaults for the top-level parameters.
    localparam int DEFAULT_DIM_BITS    = 12;
    localparam int DEFAULT_SAMPLE_BITS = 16;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_SLICE_COUNT = 3'd0,
        CFG_ROW_COUNT   = 3'd1,
        CFG_ROW_LENGTH  = 3'd2,
        CFG_RAMP_START  = 3'd3,
        CFG_RAMP_END    = 3'd4
    } cfg_reg_t;

    // Ramp operands: weight of the first sample (h - n), weight of the
    // second sample (m - h) and the divisor (m - n).
    typedef struct packed {
        logic [RAMP_BITS-1:0] up_weight;
        logic [RAMP_BITS-1:0] down_weight;
        logic [RAMP_BITS-1:0] divisor;
    } blend_op_t;

endpackage

// File: sv/srcf_blend_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// srcf_blend_unit: bit-serial weighted blend and restoring division
// Forms (h-n)*first + (m-h)*second one weight bit per cycle, MSB first, and
// then divides by (m-n) one quotient bit per cycle in the same register.
// ============================================================================
module srcf_blend_unit #(
    parameter int SAMPLE_BITS = srcf_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  srcf_pkg::blend_op_t     op,
    input  logic [SAMPLE_BITS-1:0]  first_sample,
    input  logic [SAMPLE_BITS-1:0]  second_sample,
    output logic                    done,
    output logic [SAMPLE_BITS-1:0]  quotient
);

    localparam int RB        = srcf_pkg::RAMP_BITS;
    localparam int ACC_BITS  = RB + SAMPLE_BITS;
    localparam int STEPS     = (SAMPLE_BITS > RB) ? SAMPLE_BITS : RB;
    localparam int CNT_BITS  = $clog2(STEPS);

    typedef enum logic [1:0] {
        U_IDLE,
        U_MUL,
        U_DIV
    } unit_state_t;

    unit_state_t            state_reg;
    logic [CNT_BITS-1:0]    count_reg;
    logic [SAMPLE_BITS-1:0] a_reg;
    logic [SAMPLE_BITS-1:0] b_reg;
    logic [RB-1:0]          u_reg;
    logic [RB-1:0]          v_reg;
    logic [RB-1:0]          d_reg;
    logic [ACC_BITS-1:0]    acc_reg;
    logic                   done_reg;

    logic [ACC_BITS-1:0]    mul_next;
    logic [RB:0]            div_top;
    logic [RB:0]            div_trial;
    logic [ACC_BITS-1:0]    div_next;

    // One Horner step of the weighted sum: double and add the selected samples.
    always_comb begin
        mul_next = {acc_reg[ACC_BITS-2:0], 1'b0}
                 + (u_reg[RB-1] ? ACC_BITS'(a_reg) : '0)
                 + (v_reg[RB-1] ? ACC_BITS'(b_reg) : '0);
    end

    // One restoring division step. The upper part of the accumulator holds
    // the partial remainder, which always stays below the divisor; the lower
    // part shifts out dividend bits and takes in quotient bits.
    always_comb begin
        div_top   = {acc_reg[ACC_BITS-1:SAMPLE_BITS], acc_reg[SAMPLE_BITS-1]};
        div_trial = div_top - {1'b0, d_reg};
        if (!div_trial[RB]) begin
            div_next = {div_trial[RB-1:0], acc_reg[SAMPLE_BITS-2:0], 1'b1};
        end else begin
            div_next = {div_top[RB-1:0], acc_reg[SAMPLE_BITS-2:0], 1'b0};
        end
    end

    // Sequencer: multiply phase, then divide phase, then a done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE: begin
                    if (start) begin
                        a_reg     <= first_sample;
                        b_reg     <= second_sample;
                        u_reg     <= op.up_weight;
                        v_reg     <= op.down_weight;
                        d_reg     <= op.divisor;
                        acc_reg   <= '0;
                        count_reg <= CNT_BITS'(RB - 1);
                        state_reg <= U_MUL;
                    end
                end
                U_MUL: begin
                    acc_reg <= mul_next;
                    u_reg   <= {u_reg[RB-2:0], 1'b0};
                    v_reg   <= {v_reg[RB-2:0], 1'b0};
                    if (count_reg == '0) begin
                        count_reg <= CNT_BITS'(SAMPLE_BITS - 1);
                        state_reg <= U_DIV;
                    end else begin
                        count_reg <= count_reg - CNT_BITS'(1);
                    end
                end
                U_DIV: begin
                    acc_reg <= div_next;
                    if (count_reg == '0) begin
                        done_reg  <= 1'b1;
                        state_reg <= U_IDLE;
                    end else begin
                        count_reg <= count_reg - CNT_BITS'(1);
                    end
                end
                default: begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[SAMPLE_BITS-1:0];

endmodule

// File: sv/slice_ramp_crossfade.sv
`timescale 1ns / 1ps
// ============================================================================
// slice_ramp_crossfade: linear crossfade of two volumes along the slices
// Tracks the raster position of each voxel pair, selects or blends the two
// samples by slice index and flags the last voxel of the volume.
// ============================================================================
//
//  Channel  Direction  Handshake          Content
//  s_       in         s_valid / s_ready  first_sample, second_sample
//  m_       out        m_valid / m_ready  blended_sample, last_voxel
//  cfg_     in         cfg_we             cfg_index, cfg_data
//
// An item on the ramp passes through the bit-serial multiply and the
// restoring divider in the blend unit; an item outside the ramp
// bypasses the blend unit.
// One item is in work at a time; s_ready is high while the block is idle.
// A finished result waits in the output register, so the next item may be
// taken while m_ready is low. Reset is synchronous and active low; it
// restores the register defaults and the raster position to zero.
//
module slice_ramp_crossfade #(
    parameter int DIM_BITS    = srcf_pkg::DEFAULT_DIM_BITS,
    parameter int SAMPLE_BITS = srcf_pkg::DEFAULT_SAMPLE_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration port
    input  logic                                cfg_we,
    input  logic [srcf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [srcf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    // Input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [SAMPLE_BITS-1:0]              s_first_sample,
    input  logic [SAMPLE_BITS-1:0]              s_second_sample,
    // Result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [SAMPLE_BITS-1:0]              m_blended_sample,
    output logic                                m_last_voxel
);

    localparam int CB       = srcf_pkg::COUNT_BITS;
    localparam int RB       = srcf_pkg::RAMP_BITS;
    localparam int CMP_BITS = (DIM_BITS + 1 > CB) ? DIM_BITS + 1 : CB;
    localparam int POS_BITS = (DIM_BITS > RB) ? DIM_BITS : RB;

    typedef enum logic [1:0] {
        T_IDLE,
        T_BUSY,
        T_HOLD
    } top_state_t;

    // Configuration registers.
    logic [CB-1:0] slice_count_reg;
    logic [CB-1:0] row_count_reg;
    logic [CB-1:0] row_length_reg;
    logic [RB-1:0] ramp_start_reg;
    logic [RB-1:0] ramp_end_reg;

    // Raster position of the next voxel.
    logic [DIM_BITS-1:0] sample_index_reg;
    logic [DIM_BITS-1:0] row_index_reg;
    logic [DIM_BITS-1:0] slice_index_reg;

    top_state_t             state_reg;
    logic                   use_unit_reg;
    logic [SAMPLE_BITS-1:0] hold_value_reg;
    logic                   hold_last_reg;
    logic                   m_valid_reg;
    logic [SAMPLE_BITS-1:0] m_blended_reg;
    logic                   m_last_reg;

    logic                   accept;
    logic                   s_end;
    logic                   r_end;
    logic                   h_end;
    logic [POS_BITS-1:0]    h_pos;
    logic [POS_BITS-1:0]    n_pos;
    logic [POS_BITS-1:0]    m_pos;
    logic                   below_ramp;
    logic                   above_ramp;
    logic                   out_free;
    srcf_pkg::blend_op_t    blend_op;
    logic                   unit_done;
    logic [SAMPLE_BITS-1:0] unit_quotient;

    // True when idx is the last index of a dimension holding cnt entries.
    // A zero count acts as one; the all-ones index always ends the dimension.
    function automatic logic at_end(input logic [DIM_BITS-1:0] idx,
                                    input logic [CB-1:0] cnt);
        logic [CMP_BITS-1:0] next_idx;
        next_idx = CMP_BITS'(idx) + CMP_BITS'(1);
        return (idx == {DIM_BITS{1'b1}}) || (next_idx >= CMP_BITS'(cnt));
    endfunction

    assign accept   = s_valid && (state_reg == T_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // Position tests for the item being offered.
    always_comb begin
        s_end = at_end(sample_index_reg, row_length_reg);
        r_end = at_end(row_index_reg, row_count_reg);
        h_end = at_end(slice_index_reg, slice_count_reg);
    end

    // Ramp selection. The lower end is tested first, so an empty or inverted
    // ramp gives the second sample at or below ramp_start and the first above.
    always_comb begin
        h_pos      = POS_BITS'(slice_index_reg);
        n_pos      = POS_BITS'(ramp_start_reg);
        m_pos      = POS_BITS'(ramp_end_reg);
        below_ramp = (h_pos <= n_pos);
        above_ramp = (h_pos >= m_pos);
        blend_op.up_weight   = h_pos[RB-1:0] - ramp_start_reg;
        blend_op.down_weight = ramp_end_reg - h_pos[RB-1:0];
        blend_op.divisor     = ramp_end_reg - ramp_start_reg;
    end

    srcf_blend_unit #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_blend (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (accept && !below_ramp && !above_ramp),
        .op            (blend_op),
        .first_sample  (s_first_sample),
        .second_sample (s_second_sample),
        .done          (unit_done),
        .quotient      (unit_quotient)
    );

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slice_count_reg <= CB'(1);
            row_count_reg   <= CB'(1);
            row_length_reg  <= CB'(1);
            ramp_start_reg  <= '0;
            ramp_end_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                srcf_pkg::CFG_SLICE_COUNT: slice_count_reg <= cfg_data[CB-1:0];
                srcf_pkg::CFG_ROW_COUNT:   row_count_reg   <= cfg_data[CB-1:0];
                srcf_pkg::CFG_ROW_LENGTH:  row_length_reg  <= cfg_data[CB-1:0];
                srcf_pkg::CFG_RAMP_START:  ramp_start_reg  <= cfg_data[RB-1:0];
                srcf_pkg::CFG_RAMP_END:    ramp_end_reg    <= cfg_data[RB-1:0];
                default: ;
            endcase
        end
    end

    // Raster position: advances on every accepted item and carries from the
    // sample index to the row index to the slice index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_index_reg <= '0;
            row_index_reg    <= '0;
            slice_index_reg  <= '0;
        end else if (accept) begin
            if (!s_end) begin
                sample_index_reg <= sample_index_reg + DIM_BITS'(1);
            end else begin
                sample_index_reg <= '0;
                if (!r_end) begin
                    row_index_reg <= row_index_reg + DIM_BITS'(1);
                end else begin
                    row_index_reg <= '0;
                    if (!h_end) begin
                        slice_index_reg <= slice_index_reg + DIM_BITS'(1);
                    end else begin
                        slice_index_reg <= '0;
                    end
                end
            end
        end
    end

    // Item control and output register. In the hold state a result taken
    // from the output register is replaced by the waiting one.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != T_HOLD)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (accept) begin
                        hold_last_reg  <= s_end && r_end && h_end;
                        hold_value_reg <= below_ramp ? s_second_sample
                                                     : s_first_sample;
                        if (below_ramp || above_ramp) begin
                            use_unit_reg <= 1'b0;
                            state_reg    <= T_HOLD;
                        end else begin
                            use_unit_reg <= 1'b1;
                            state_reg    <= T_BUSY;
                        end
                    end
                end
                T_BUSY: begin
                    if (unit_done) begin
                        state_reg <= T_HOLD;
                    end
                end
                T_HOLD: begin
                    if (out_free) begin
                        m_blended_reg <= use_unit_reg ? unit_quotient : hold_value_reg;
                        m_last_reg    <= hold_last_reg;
                        m_valid_reg   <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default: begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign s_ready          = (state_reg == T_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_blended_sample = m_blended_reg;
    assign m_last_voxel     = m_last_reg;

endmodule

// File: bench/slice_ramp_crossfade_test.sv
`timescale 1ns / 1ps
// ============================================================================
// slice_ramp_crossfade_test: self-checking bench for the slice crossfade
// Streams voxel pairs through the block under several volume shapes and ramp
// settings, predicts every blended item and its last-voxel flag from a model
// of the raster position and the ramp, and compares each result in order.
// ============================================================================
module slice_ramp_crossfade_test;

    localparam int DIM_BITS       = srcf_pkg::DEFAULT_DIM_BITS;
    localparam int SAMPLE_BITS    = srcf_pkg::DEFAULT_SAMPLE_BITS;
    localparam int RAMP_BITS      = srcf_pkg::RAMP_BITS;
    localparam int COUNT_BITS     = srcf_pkg::COUNT_BITS;
    localparam int CFG_INDEX_BITS = srcf_pkg::CFG_INDEX_BITS;
    localparam int CFG_DATA_BITS  = srcf_pkg::CFG_DATA_BITS;

    // Worst case cycles for one item on the ramp, plus some margin after it.
    localparam int BLEND_LATENCY  = RAMP_BITS + SAMPLE_BITS + 3;
    localparam int SETTLE_CYCLES  = BLEND_LATENCY + 8;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 600;
    localparam int SWEEP_SLICES   = 1 << DIM_BITS;
    localparam int SWEEP_ITEMS    = 256;

    // An index that selects no register at all.
    localparam logic [CFG_INDEX_BITS-1:0] SPARE_REG_INDEX = 3'd7;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;
    localparam logic [RAMP_BITS-1:0]   RAMP_MAX   = '1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] blended;
        logic                   last;
    } crossfade_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: a copy of the registers and the raster position, and the
    // queue of blended items still to come out of the block.
    // ------------------------------------------------------------------------
    class crossfade_scoreboard;
        logic [COUNT_BITS-1:0] slice_count;
        logic [COUNT_BITS-1:0] row_count;
        logic [COUNT_BITS-1:0] row_length;
        logic [RAMP_BITS-1:0]  ramp_start;
        logic [RAMP_BITS-1:0]  ramp_end;
        logic [DIM_BITS-1:0]   sample_pos;
        logic [DIM_BITS-1:0]   row_pos;
        logic [DIM_BITS-1:0]   slice_pos;
        crossfade_result_t     expected_blends[$];
        int                    errors;

        function new();
            slice_count = 1;
            row_count   = 1;
            row_length  = 1;
            ramp_start  = 0;
            ramp_end    = 0;
            sample_pos  = 0;
            row_pos     = 0;
            slice_pos   = 0;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx,
                                logic [CFG_DATA_BITS-1:0] data);
            case (idx)
                srcf_pkg::CFG_SLICE_COUNT: slice_count = data[COUNT_BITS-1:0];
                srcf_pkg::CFG_ROW_COUNT:   row_count   = data[COUNT_BITS-1:0];
                srcf_pkg::CFG_ROW_LENGTH:  row_length  = data[COUNT_BITS-1:0];
                srcf_pkg::CFG_RAMP_START:  ramp_start  = data[RAMP_BITS-1:0];
                srcf_pkg::CFG_RAMP_END:    ramp_end    = data[RAMP_BITS-1:0];
                default: ;
            endcase
        endfunction

        // A zero count behaves as one and an index at all ones always wraps,
        // which also covers counts above the index range.
        function bit at_end(logic [DIM_BITS-1:0] idx, logic [COUNT_BITS-1:0] cnt);
            return (&idx) || (int'(idx) + 1 >= int'(cnt));
        endfunction

        function logic [SAMPLE_BITS-1:0] blend_expected(logic [DIM_BITS-1:0] h,
                                                        logic [SAMPLE_BITS-1:0] a,
                                                        logic [SAMPLE_BITS-1:0] b);
            longint unsigned n, m, hh, acc;
            n  = ramp_start;
            m  = ramp_end;
            hh = h;
            // The lower end is tested first, so an empty or inverted ramp
            // gives the second sample up to ramp_start and the first above.
            if (hh <= n) return b;
            if (hh >= m) return a;
            acc = (hh - n) * a + (m - hh) * b;
            return SAMPLE_BITS'(acc / (m - n));
        endfunction

        function void note_voxel(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b);
            bit s_end, r_end, h_end;
            crossfade_result_t r;
            s_end = at_end(sample_pos, row_length);
            r_end = at_end(row_pos, row_count);
            h_end = at_end(slice_pos, slice_count);
            r.blended = blend_expected(slice_pos, a, b);
            r.last    = s_end && r_end && h_end;
            expected_blends.push_back(r);
            if (!s_end) begin
                sample_pos++;
            end else begin
                sample_pos = 0;
                if (!r_end) begin
                    row_pos++;
                end else begin
                    row_pos = 0;
                    if (!h_end) slice_pos++;
                    else        slice_pos = 0;
                end
            end
        endfunction

        function void check_blend(logic [SAMPLE_BITS-1:0] blended, logic last);
            crossfade_result_t want;
            if (expected_blends.size() == 0) begin
                $display("[%0t] unexpected item: blended_sample %0h last_voxel %0b",
                         $time, blended, last);
                errors++;
                return;
            end
            want = expected_blends.pop_front();
            if (blended !== want.blended) begin
                $display("[%0t] blended_sample mismatch: expected %0h, actual %0h",
                         $time, want.blended, blended);
                errors++;
            end
            if (last !== want.last) begin
                $display("[%0t] last_voxel mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return expected_blends.size();
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      s_valid;
    logic                      s_ready;
    logic [SAMPLE_BITS-1:0]    s_first_sample;
    logic [SAMPLE_BITS-1:0]    s_second_sample;
    logic                      m_valid;
    logic                      m_ready;
    logic [SAMPLE_BITS-1:0]    m_blended_sample;
    logic                      m_last_voxel;

    crossfade_scoreboard sb;
    bit                  long_hold_request;
    bit                  burst_phase;
    int                  random_items;

    slice_ramp_crossfade #(
        .DIM_BITS    (DIM_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_sample   (s_first_sample),
        .s_second_sample  (s_second_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_blended_sample (m_blended_sample),
        .m_last_voxel     (m_last_voxel)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Random choices for gaps, samples and register values.
    // ------------------------------------------------------------------------
    function automatic int pick_gap(bit no_idle);
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle)   return 0;
        if (roll < 70) return 0;
        if (roll < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return SAMPLE_MAX;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // Mostly small volumes, now and then a zero or an out-of-range count.
    function automatic logic [CFG_DATA_BITS-1:0] pick_count();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return CFG_DATA_BITS'(SWEEP_SLICES);
            2:       return CFG_DATA_BITS'($urandom_range(SWEEP_SLICES + 1, COUNT_MAX));
            3:       return CFG_DATA_BITS'($urandom_range(0, COUNT_MAX));
            default: return CFG_DATA_BITS'($urandom_range(1, 5));
        endcase
    endfunction

    // Ramp ends close to the slices actually reached, with wide values now
    // and then to exercise the masking of the top data bit.
    function automatic logic [CFG_DATA_BITS-1:0] pick_ramp();
        if ($urandom_range(0, 9) == 0) return CFG_DATA_BITS'($urandom_range(0, COUNT_MAX));
        return CFG_DATA_BITS'($urandom_range(0, 8));
    endfunction

    // ------------------------------------------------------------------------
    // Driving tasks. Each starts and ends just after a rising edge.
    // ------------------------------------------------------------------------
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [CFG_DATA_BITS-1:0] slices, logic [CFG_DATA_BITS-1:0] rows,
                             logic [CFG_DATA_BITS-1:0] length, logic [CFG_DATA_BITS-1:0] n,
                             logic [CFG_DATA_BITS-1:0] m);
        write_reg(srcf_pkg::CFG_SLICE_COUNT, slices);
        write_reg(srcf_pkg::CFG_ROW_COUNT, rows);
        write_reg(srcf_pkg::CFG_ROW_LENGTH, length);
        write_reg(srcf_pkg::CFG_RAMP_START, n);
        write_reg(srcf_pkg::CFG_RAMP_END, m);
        cfg_we <= 1'b0;
    endtask

    // Valid stays high across back-to-back items; it only drops for a gap.
    task automatic send_voxel(logic [SAMPLE_BITS-1:0] a, logic [SAMPLE_BITS-1:0] b, int gap);
        s_valid         <= 1'b1;
        s_first_sample  <= a;
        s_second_sample <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_voxel(a, b);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Registers may only change once every item has drained out.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic send_random_voxels(int count);
        repeat (count) begin
            send_voxel(pick_sample(), pick_sample(), pick_gap(burst_phase));
        end
    endtask

    // ------------------------------------------------------------------------
    // Result side: stalls of random length, and one long hold-off on request
    // so that the block fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                stall = LONG_HOLD;
            end else begin
                stall = pick_gap(1'b0);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 150)) @(posedge aclk);
            else repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    end

    // Every accepted result is checked against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1)
            sb.check_blend(m_blended_sample, m_last_voxel);
    end

    // Watchdog: ends the run when no item moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [SAMPLE_BITS-1:0] corner_a[4];
        logic [SAMPLE_BITS-1:0] corner_b[4];
        int                     phase;
        int                     phase_len;

        sb                = new();
        long_hold_request = 1'b0;
        burst_phase       = 1'b0;
        random_items      = 0;
        corner_a = '{SAMPLE_MAX, '0, SAMPLE_MAX, '0};
        corner_b = '{'0, SAMPLE_MAX, SAMPLE_MAX, '0};

        aresetn         <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= srcf_pkg::CFG_SLICE_COUNT;
        cfg_data        <= '0;
        s_valid         <= 1'b0;
        s_first_sample  <= '0;
        s_second_sample <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset values: a single-voxel volume with an empty ramp at zero.
        send_voxel(SAMPLE_MAX, '0, 0);
        send_voxel('0, SAMPLE_MAX, 1);
        wait_idle();

        // Five slices of two voxels across a ramp from 1 to 4, with the
        // corner sample values on every voxel.
        configure(5, 1, 2, 1, 4);
        for (int i = 0; i < 10; i++) send_voxel(corner_a[i % 4], corner_b[i % 4], i % 3);
        wait_idle();

        // Inverted ramp with a zero row length; the spare index changes nothing.
        write_reg(SPARE_REG_INDEX, COUNT_MAX);
        configure(5, 1, 0, 3, 1);
        for (int i = 0; i < 5; i++) send_voxel(corner_a[i % 4], corner_b[(i + 1) % 4], 0);
        wait_idle();

        // Slice count lowered below the current slice part way through a volume.
        configure(6, 1, 1, 0, 5);
        for (int i = 0; i < 3; i++) send_voxel(SAMPLE_MAX, corner_b[i % 4], 0);
        wait_idle();
        write_reg(srcf_pkg::CFG_SLICE_COUNT, 2);
        cfg_we <= 1'b0;
        send_voxel(SAMPLE_MAX, '0, 0);
        send_voxel('0, SAMPLE_MAX, 0);
        wait_idle();

        // A long climb up the widest ramp, one voxel per slice, with an
        // all-ones slice count that behaves as the full index range.
        configure(COUNT_MAX, 1, 1, 0, CFG_DATA_BITS'(RAMP_MAX));
        for (int blk = 0; blk < SWEEP_ITEMS / 64; blk++) begin
            burst_phase = ($urandom_range(0, 3) == 0);
            send_random_voxels(64);
        end
        wait_idle();

        // Random phases: new register values between phases, the raster
        // position carried over, so counts often change mid-volume.
        phase = 0;
        while (random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 1)) write_reg(srcf_pkg::CFG_SLICE_COUNT, pick_count());
            if ($urandom_range(0, 1)) write_reg(srcf_pkg::CFG_ROW_COUNT, pick_count());
            if ($urandom_range(0, 1)) write_reg(srcf_pkg::CFG_ROW_LENGTH, pick_count());
            if ($urandom_range(0, 1)) write_reg(srcf_pkg::CFG_RAMP_START, pick_ramp());
            if ($urandom_range(0, 1)) write_reg(srcf_pkg::CFG_RAMP_END, pick_ramp());
            if ($urandom_range(0, 15) == 0)
                write_reg(SPARE_REG_INDEX, CFG_DATA_BITS'($urandom_range(0, COUNT_MAX)));
            cfg_we <= 1'b0;

            burst_phase = ($urandom_range(0, 3) == 0);
            phase_len   = $urandom_range(10, 60);
            // One phase keeps the sender busy while the result side holds off.
            if (phase == 1) begin
                burst_phase       = 1'b1;
                long_hold_request = 1'b1;
                phase_len         = 30;
                // Start sending only once the result side has begun its hold.
                wait (long_hold_request == 1'b0);
            end
            send_random_voxels(phase_len);
            random_items += phase_len;
            phase++;
            wait_idle();
        end

        if (sb.pending() != 0) begin
            $display("[%0t] %0d expected items never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
